// ----- rtl/assert_macros.svh -----
// assertion macros used by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition implies the expression in the same cycle
`define AST_IMPL(name, cond, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("assertion failed");

// condition implies the expression in the next cycle
`define AST_NEXT(name, cond, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("assertion failed");

`endif

// ----- rtl/tbo_pkg.sv -----
// types and constants of the triangle box overlap test
`timescale 1ns / 1ps
package tbo_pkg;

    localparam int P_W = 35;    // relative vertex coordinate, twice the q16.16 value
    localparam int D_W = 36;    // edge direction and distance to face
    localparam int X_W = 72;    // cross product term
    localparam int N_W = 73;    // plane normal component
    localparam int Q_W = 73;    // edge crossing numerator
    localparam int H_W = 68;    // half size times direction
    localparam int S_W = 110;   // plane dot products

    typedef logic signed [P_W-1:0] pos_t;
    typedef logic signed [D_W-1:0] dir_t;
    typedef logic signed [N_W-1:0] nrm_t;
    typedef logic signed [Q_W-1:0] qnum_t;
    typedef logic signed [S_W-1:0] dot_t;

    typedef enum logic [2:0] {
        REG_ORIGIN_X = 3'd0,
        REG_ORIGIN_Y = 3'd1,
        REG_ORIGIN_Z = 3'd2,
        REG_SIZE_X   = 3'd3,
        REG_SIZE_Y   = 3'd4,
        REG_SIZE_Z   = 3'd5
    } reg_idx_t;

    typedef enum logic [1:0] {
        DEC_NONE   = 2'd0,
        DEC_VERTEX = 2'd1,
        DEC_EDGE   = 2'd2,
        DEC_PLANE  = 2'd3
    } decided_t;

endpackage

// ----- rtl/tbo_mul.sv -----
// pipelined signed multiplier built from 32x32 partial products
`timescale 1ns / 1ps
module tbo_mul #(
    parameter int AW = 36,
    parameter int BW = 36
) (
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [AW-1:0]    a,
    input  logic signed [BW-1:0]    b,
    output logic signed [AW+BW-1:0] p
);

    localparam int NA = (AW + 31) / 32;
    localparam int NB = (BW + 31) / 32;
    localparam int PW = AW + BW;
    localparam int XW = (NA + NB) * 32;

    logic [AW-1:0]      ma;
    logic [BW-1:0]      mb;
    logic [NA*32-1:0]   ua_reg;
    logic [NB*32-1:0]   ub_reg;
    logic               sgn1_reg;
    logic               sgn2_reg;
    logic               sgn3_reg;
    logic [63:0]        pp_reg [NA][NB];
    logic [PW-1:0]      sum_next;
    logic [PW-1:0]      sum_reg;
    logic signed [PW-1:0] p_reg;

    assign ma = a[AW-1] ? $unsigned(-a) : $unsigned(a);
    assign mb = b[BW-1] ? $unsigned(-b) : $unsigned(b);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ua_reg   <= (NA*32)'(ma);
            ub_reg   <= (NB*32)'(mb);
            sgn1_reg <= a[AW-1] ^ b[BW-1];
            sgn2_reg <= sgn1_reg;
            sgn3_reg <= sgn2_reg;
        end
    end

    for (genvar i = 0; i < NA; i++)
    begin : g_pa
        for (genvar j = 0; j < NB; j++)
        begin : g_pb
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    pp_reg[i][j] <= ua_reg[32*i +: 32] * ub_reg[32*j +: 32];
                end
            end
        end
    end

    always_comb
    begin
        sum_next = '0;
        for (int i = 0; i < NA; i++)
        begin
            for (int j = 0; j < NB; j++)
            begin
                sum_next = sum_next + PW'(XW'(pp_reg[i][j]) << (32 * (i + j)));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg <= sum_next;
            p_reg   <= sgn3_reg ? -$signed(sum_reg) : $signed(sum_reg);
        end
    end

    assign p = p_reg;

endmodule

// ----- rtl/triangle_box_overlap_test.sv -----
// triangle against axis-aligned box overlap test, top level
// throughput: one item per cycle while the skid stage is empty, set by the fully pipelined multiplier stages
// a one-item skid stage behind the output register takes one more item under stall
// reset clears all valid bits and the box registers to zero
`timescale 1ns / 1ps
`include "assert_macros.svh"
module triangle_box_overlap_test
    import tbo_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_addr,
    input  logic [31:0]  cfg_wr_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // vertex0_x, vertex0_y, vertex0_z, vertex1_x .. vertex2_z, 32 bits each
    input  logic [287:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // overlaps, decided_by[1:0], 5 zero bits
    output logic [7:0]   m_tdata
);

    localparam int LAST = 14;

    // box registers
    logic signed [31:0] org_reg  [3];
    logic [30:0]        size_reg [3];

    // control
    logic               en;
    logic [LAST:1]      v_reg;
    logic               out_vld_reg;
    logic               skid_vld_reg;
    logic [2:0]         out_reg;
    logic [2:0]         skid_reg;
    logic [2:0]         res;
    logic               push;

    // stage 1..2
    pos_t               p1_reg [3][3];
    pos_t               p2_reg [3][3];
    dir_t               d2_reg [3][3];
    dir_t               n2_reg [3][3];
    dir_t               b2_reg [3];
    logic [5:0]         c2_reg [3];
    dir_t               d_next [3][3];
    dir_t               n_next [3][3];
    logic [5:0]         c_next [3];

    // edge test
    logic [D_W-1:0]     an3_reg [3][3];
    logic [D_W-1:0]     ad3_reg [3][3];
    logic [8:0]         pre3_reg;
    logic [8:0]         el_reg [4:8];
    logic signed [P_W+D_W-1:0] pdk [3][3][2];
    logic signed [2*D_W-1:0]   dn  [3][3][2];
    logic signed [H_W-1:0]     hd  [3][3][2];
    qnum_t              q7_reg  [3][3][2];
    logic [H_W-1:0]     hd7_reg [3][3][2];
    logic [Q_W-1:0]     q8_reg  [3][3][2];
    logic [H_W-1:0]     hd8_reg [3][3][2];
    logic [8:0]         ok;

    // flags carried down the pipe
    logic               vin_reg [3:LAST];
    logic               com_reg [3:LAST];
    logic               hit_reg [9:LAST];

    // plane test
    pos_t               p0d_reg [3:7][3];
    logic signed [X_W-1:0]     xp [6];
    nrm_t               nv7_reg [3];
    logic signed [N_W+P_W-1:0] np [3];
    logic signed [N_W+31:0]    nh [3];
    dot_t               cd12_reg;
    dot_t               vp12_reg;
    dot_t               vm12_reg;
    dot_t               hz12_reg;
    dot_t               ev13_reg [4];
    dot_t               cd13_reg;
    logic [S_W-1:0]     ea14_reg [4];
    logic [S_W-1:0]     ca14_reg;
    logic [3:0]         gt;

    assign en       = !skid_vld_reg;
    assign s_tready = en;
    assign push     = v_reg[LAST] && en;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 3; k++)
            begin
                org_reg[k]  <= '0;
                size_reg[k] <= '0;
            end
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                REG_ORIGIN_X: org_reg[0]  <= $signed(cfg_wr_data);
                REG_ORIGIN_Y: org_reg[1]  <= $signed(cfg_wr_data);
                REG_ORIGIN_Z: org_reg[2]  <= $signed(cfg_wr_data);
                REG_SIZE_X:   size_reg[0] <= cfg_wr_data[30:0];
                REG_SIZE_Y:   size_reg[1] <= cfg_wr_data[30:0];
                REG_SIZE_Z:   size_reg[2] <= cfg_wr_data[30:0];
                default:      ;
            endcase
        end
    end

    // valid bits and output with skid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg        <= '0;
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else
        begin
            if (en)
            begin
                v_reg <= {v_reg[LAST-1:1], s_tvalid};
            end
            if (!out_vld_reg || m_tready)
            begin
                if (skid_vld_reg)
                begin
                    out_vld_reg  <= 1'b1;
                    skid_vld_reg <= 1'b0;
                end
                else
                begin
                    out_vld_reg <= push;
                end
            end
            else if (push)
            begin
                skid_vld_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_vld_reg || m_tready)
        begin
            out_reg <= skid_vld_reg ? skid_reg : res;
        end
        else if (push)
        begin
            skid_reg <= res;
        end
    end

    // stage 2 combinational: directions, face distances, outcodes
    always_comb
    begin
        for (int e = 0; e < 3; e++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                d_next[e][k] = D_W'(p1_reg[(e + 1) % 3][k]) - D_W'(p1_reg[e][k]);
                n_next[e][k] = (p1_reg[e][k] > 0)
                    ? $signed(D_W'(size_reg[k])) - D_W'(p1_reg[e][k])
                    : -$signed(D_W'(size_reg[k])) - D_W'(p1_reg[e][k]);
                c_next[e][2*k]   = D_W'(p1_reg[e][k]) < -$signed(D_W'(size_reg[k]));
                c_next[e][2*k+1] = D_W'(p1_reg[e][k]) > $signed(D_W'(size_reg[k]));
            end
        end
    end

    // final comparisons of the edge test and the plane test
    always_comb
    begin
        for (int e = 0; e < 3; e++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                ok[3*e+k] = el_reg[8][3*e+k]
                    && (q8_reg[e][k][0] < Q_W'(hd8_reg[e][k][0]))
                    && (q8_reg[e][k][1] < Q_W'(hd8_reg[e][k][1]));
            end
        end
        for (int q = 0; q < 4; q++)
        begin
            gt[q] = ea14_reg[q] > ca14_reg;
        end
    end

    always_comb
    begin
        if (vin_reg[LAST])
        begin
            res = {DEC_VERTEX, 1'b1};
        end
        else if (hit_reg[LAST])
        begin
            res = {DEC_EDGE, 1'b1};
        end
        else if (com_reg[LAST] && (|gt))
        begin
            res = {DEC_PLANE, 1'b1};
        end
        else
        begin
            res = {DEC_NONE, 1'b0};
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // stage 1: twice the vertex minus twice the box centre
            for (int i = 0; i < 3; i++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    p1_reg[i][k] <= P_W'(
                        {{3{s_tdata[32*(3*i+k)+31]}}, s_tdata[32*(3*i+k) +: 32], 1'b0}
                        - {{3{org_reg[k][31]}}, org_reg[k], 1'b0}
                        - {5'd0, size_reg[k]});
                end
            end
            // stage 2
            p2_reg <= p1_reg;
            d2_reg <= d_next;
            n2_reg <= n_next;
            c2_reg <= c_next;
            for (int k = 0; k < 3; k++)
            begin
                b2_reg[k] <= D_W'(p1_reg[2][k]) - D_W'(p1_reg[0][k]);
            end
            // stage 3: magnitudes and sign checks
            for (int e = 0; e < 3; e++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    an3_reg[e][k] <= n2_reg[e][k][D_W-1] ? $unsigned(-n2_reg[e][k])
                                                         : $unsigned(n2_reg[e][k]);
                    ad3_reg[e][k] <= d2_reg[e][k][D_W-1] ? $unsigned(-d2_reg[e][k])
                                                         : $unsigned(d2_reg[e][k]);
                    pre3_reg[3*e+k] <= (d2_reg[e][k] != '0) && (n2_reg[e][k] != '0)
                        && (n2_reg[e][k][D_W-1] == d2_reg[e][k][D_W-1]);
                end
            end
            vin_reg[3] <= (c2_reg[0] == '0) || (c2_reg[1] == '0) || (c2_reg[2] == '0);
            com_reg[3] <= (c2_reg[0] & c2_reg[1] & c2_reg[2]) == '0;
            p0d_reg[3] <= p2_reg[0];
            // stage 4: crossing parameter strictly inside the edge
            for (int e = 0; e < 3; e++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    el_reg[4][3*e+k] <= pre3_reg[3*e+k] && (an3_reg[e][k] < ad3_reg[e][k]);
                end
            end
            for (int s = 5; s <= 8; s++)
            begin
                el_reg[s] <= el_reg[s-1];
            end
            for (int s = 4; s <= 7; s++)
            begin
                p0d_reg[s] <= p0d_reg[s-1];
            end
            for (int s = 4; s <= LAST; s++)
            begin
                vin_reg[s] <= vin_reg[s-1];
                com_reg[s] <= com_reg[s-1];
            end
            // stages 7 and 8: crossing numerator, its magnitude and plane normal
            for (int e = 0; e < 3; e++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    for (int m = 0; m < 2; m++)
                    begin
                        q7_reg[e][k][m]  <= Q_W'(pdk[e][k][m]) + Q_W'(dn[e][k][m]);
                        hd7_reg[e][k][m] <= hd[e][k][m][H_W-1] ? $unsigned(-hd[e][k][m])
                                                               : $unsigned(hd[e][k][m]);
                        q8_reg[e][k][m]  <= q7_reg[e][k][m][Q_W-1]
                            ? $unsigned(-q7_reg[e][k][m]) : $unsigned(q7_reg[e][k][m]);
                        hd8_reg[e][k][m] <= hd7_reg[e][k][m];
                    end
                end
            end
            for (int k = 0; k < 3; k++)
            begin
                nv7_reg[k] <= N_W'(xp[2*k]) - N_W'(xp[2*k+1]);
            end
            // stage 9: edge crossing found
            hit_reg[9] <= |ok;
            for (int s = 10; s <= LAST; s++)
            begin
                hit_reg[s] <= hit_reg[s-1];
            end
            // stage 12..14: plane against the box corner pairs
            cd12_reg <= S_W'(np[0]) + S_W'(np[1]) + S_W'(np[2]);
            vp12_reg <= S_W'(nh[1]) + S_W'(nh[0]);
            vm12_reg <= S_W'(nh[1]) - S_W'(nh[0]);
            hz12_reg <= S_W'(nh[2]);
            ev13_reg[0] <= vp12_reg + hz12_reg;
            ev13_reg[1] <= vp12_reg - hz12_reg;
            ev13_reg[2] <= vm12_reg + hz12_reg;
            ev13_reg[3] <= vm12_reg - hz12_reg;
            cd13_reg    <= cd12_reg;
            for (int q = 0; q < 4; q++)
            begin
                ea14_reg[q] <= ev13_reg[q][S_W-1] ? $unsigned(-ev13_reg[q])
                                                  : $unsigned(ev13_reg[q]);
            end
            ca14_reg <= cd13_reg[S_W-1] ? $unsigned(-cd13_reg) : $unsigned(cd13_reg);
        end
    end

    // edge products: stages 3 to 6
    for (genvar e = 0; e < 3; e++)
    begin : g_edg
        for (genvar k = 0; k < 3; k++)
        begin : g_ax
            for (genvar m = 0; m < 2; m++)
            begin : g_oth
                localparam int J = (k + m + 1) % 3;
                tbo_mul #(.AW(P_W), .BW(D_W)) u_pdk (
                    .clk (clk), .en (en),
                    .a (p2_reg[e][J]), .b (d2_reg[e][k]), .p (pdk[e][k][m])
                );
                tbo_mul #(.AW(D_W), .BW(D_W)) u_dn (
                    .clk (clk), .en (en),
                    .a (d2_reg[e][J]), .b (n2_reg[e][k]), .p (dn[e][k][m])
                );
                tbo_mul #(.AW(32), .BW(D_W)) u_hd (
                    .clk (clk), .en (en),
                    .a ($signed({1'b0, size_reg[J]})), .b (d2_reg[e][k]), .p (hd[e][k][m])
                );
            end
        end
    end

    // normal terms: stages 3 to 6, dot products: stages 8 to 11
    for (genvar k = 0; k < 3; k++)
    begin : g_nrm
        tbo_mul #(.AW(D_W), .BW(D_W)) u_x0 (
            .clk (clk), .en (en),
            .a (d2_reg[0][(k + 1) % 3]), .b (b2_reg[(k + 2) % 3]), .p (xp[2*k])
        );
        tbo_mul #(.AW(D_W), .BW(D_W)) u_x1 (
            .clk (clk), .en (en),
            .a (d2_reg[0][(k + 2) % 3]), .b (b2_reg[(k + 1) % 3]), .p (xp[2*k+1])
        );
        tbo_mul #(.AW(N_W), .BW(P_W)) u_np (
            .clk (clk), .en (en),
            .a (nv7_reg[k]), .b (p0d_reg[7][k]), .p (np[k])
        );
        tbo_mul #(.AW(N_W), .BW(32)) u_nh (
            .clk (clk), .en (en),
            .a (nv7_reg[k]), .b ($signed({1'b0, size_reg[k]})), .p (nh[k])
        );
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {5'd0, out_reg};

    `AST_IMPL(a_skid_needs_out, skid_vld_reg, out_vld_reg)
    `AST_NEXT(a_stall_fills_skid, push && out_vld_reg && !m_tready, skid_vld_reg)
    `AST_NEXT(a_skid_drains, skid_vld_reg && m_tready, !skid_vld_reg && out_vld_reg)

endmodule
